[sv/drsc_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// drsc_pkg - dual rate sample capture shared definitions
// Field widths, register indexes, reset values and the result beat type.
// ----------------------------------------------------------------------------
package drsc_pkg;

  localparam int IDX_W      = 11;
  localparam int SAMPLE_W   = 16;
  localparam int PHASE_W    = 8;
  localparam int CFG_DATA_W = 11;
  localparam int CFG_IDX_W  = 2;

  localparam int BUFFER_DEPTH_DEF = 2048;

  localparam logic [CFG_IDX_W-1:0] CFG_CH1_LENGTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_CH23_LENGTH = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_DECIM_RATIO = 2'd2;

  localparam logic [IDX_W-1:0]   CH1_LENGTH_RST  = 11'd1000;
  localparam logic [IDX_W-1:0]   CH23_LENGTH_RST = 11'd1000;
  localparam logic [PHASE_W-1:0] DECIM_RATIO_RST = 8'd1;

  typedef struct packed {
    logic [IDX_W-1:0]    ch1_addr;
    logic [SAMPLE_W-1:0] ch1_data;
    logic [IDX_W-1:0]    slow_addr;
    logic [SAMPLE_W-1:0] ch2_data;
    logic [SAMPLE_W-1:0] ch3_data;
    logic                ch1_full;
    logic                block_done;
  } res_t;

endpackage

[sv/drsc_idx.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// drsc_idx - configuration registers and capture index state
// Holds the fast and slow indices and the decimation phase, and forms the
// write command for each accepted tick.
// ----------------------------------------------------------------------------
module drsc_idx #(
  parameter int BUFFER_DEPTH = drsc_pkg::BUFFER_DEPTH_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_we,
  input  logic [drsc_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [drsc_pkg::CFG_DATA_W-1:0]     cfg_data,
  input  logic                                fire,
  input  logic [drsc_pkg::SAMPLE_W-1:0]       ch1_sample,
  input  logic [drsc_pkg::SAMPLE_W-1:0]       ch2_sample,
  input  logic [drsc_pkg::SAMPLE_W-1:0]       ch3_sample,
  output drsc_pkg::res_t                      res
);

  localparam int IW      = drsc_pkg::IDX_W;
  localparam int PW      = drsc_pkg::PHASE_W;
  localparam int CAP_INT = ((BUFFER_DEPTH - 1) > ((1 << IW) - 1)) ?
                           ((1 << IW) - 1) : (BUFFER_DEPTH - 1);
  localparam logic [IW-1:0] IDX_CAP = IW'(CAP_INT);

  logic [IW-1:0] ch1_len_r, ch23_len_r;
  logic [PW-1:0] ratio_r;
  logic [IW-1:0] fast_r, fast_nxt, slow_r, slow_nxt;
  logic [PW-1:0] phase_r, phase_nxt;

  logic [PW-1:0] ratio_eff;
  logic [PW:0]   phase_p1;
  logic          slow_step;
  logic [IW-1:0] fast_upd, slow_upd;
  logic          full, done;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ch1_len_r  <= drsc_pkg::CH1_LENGTH_RST;
      ch23_len_r <= drsc_pkg::CH23_LENGTH_RST;
      ratio_r    <= drsc_pkg::DECIM_RATIO_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        drsc_pkg::CFG_CH1_LENGTH:  ch1_len_r  <= cfg_data;
        drsc_pkg::CFG_CH23_LENGTH: ch23_len_r <= cfg_data;
        drsc_pkg::CFG_DECIM_RATIO: ratio_r    <= cfg_data[PW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    // treat a zero ratio as one
    ratio_eff = (ratio_r == '0) ? PW'(1) : ratio_r;
    phase_p1  = {1'b0, phase_r} + (PW+1)'(1);
    // a lowered ratio still steps at once rather than letting the phase wrap
    slow_step = (phase_p1 >= {1'b0, ratio_eff});

    fast_upd = ((fast_r <= ch1_len_r) && (fast_r < IDX_CAP)) ? fast_r + IW'(1) : fast_r;
    slow_upd = (slow_step && (slow_r < IDX_CAP)) ? slow_r + IW'(1) : slow_r;

    full = (fast_upd > ch1_len_r);
    done = (slow_upd > ch23_len_r);

    fast_nxt  = fast_r;
    slow_nxt  = slow_r;
    phase_nxt = phase_r;
    if (fire) begin
      if (done) begin
        fast_nxt  = '0;
        slow_nxt  = '0;
        phase_nxt = '0;
      end else begin
        fast_nxt  = fast_upd;
        slow_nxt  = slow_upd;
        phase_nxt = slow_step ? '0 : phase_p1[PW-1:0];
      end
    end

    res.ch1_addr   = fast_r;
    res.ch1_data   = ch1_sample;
    res.slow_addr  = slow_r;
    res.ch2_data   = ch2_sample;
    res.ch3_data   = ch3_sample;
    res.ch1_full   = full;
    res.block_done = done;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fast_r  <= '0;
      slow_r  <= '0;
      phase_r <= '0;
    end else begin
      fast_r  <= fast_nxt;
      slow_r  <= slow_nxt;
      phase_r <= phase_nxt;
    end
  end

  a_done_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (fire && done) |=> (fast_r == '0 && slow_r == '0 && phase_r == '0))
    else $error("block completion did not clear the index state");

  a_fast_capped: assert property (@(posedge clk) disable iff (!rst_n)
    fast_r <= IDX_CAP)
    else $error("fast index beyond buffer ceiling");

  a_slow_capped: assert property (@(posedge clk) disable iff (!rst_n)
    slow_r <= IDX_CAP)
    else $error("slow index beyond buffer ceiling");

endmodule

[sv/drsc_skid.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// drsc_skid - result register with skid stage
// Registers each result beat and parks one extra beat while the sink stalls,
// so the input stall is a plain register.
// ----------------------------------------------------------------------------
module drsc_skid (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           fire,
  input  drsc_pkg::res_t res,
  output logic           up_stall,
  output logic           out_valid,
  input  logic           out_stall,
  output drsc_pkg::res_t out_res
);

  logic           out_valid_r, out_valid_nxt;
  logic           skid_valid_r, skid_valid_nxt;
  drsc_pkg::res_t out_res_r, out_res_nxt;
  drsc_pkg::res_t skid_res_r, skid_res_nxt;
  logic           out_free;

  always_comb begin
    out_free       = !out_valid_r || !out_stall;
    out_valid_nxt  = out_valid_r;
    skid_valid_nxt = skid_valid_r;
    out_res_nxt    = out_res_r;
    skid_res_nxt   = skid_res_r;
    if (out_free) begin
      // drain the skid beat first, otherwise take the new beat
      out_valid_nxt  = skid_valid_r || fire;
      out_res_nxt    = skid_valid_r ? skid_res_r : res;
      skid_valid_nxt = 1'b0;
    end else if (fire) begin
      skid_valid_nxt = 1'b1;
      skid_res_nxt   = res;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      out_valid_r  <= out_valid_nxt;
      skid_valid_r <= skid_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_res_r  <= out_res_nxt;
    skid_res_r <= skid_res_nxt;
  end

  assign up_stall  = skid_valid_r;
  assign out_valid = out_valid_r;
  assign out_res   = out_res_r;

  a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r |-> out_valid_r)
    else $error("skid beat held with empty result register");

  a_skid_drains: assert property (@(posedge clk) disable iff (!rst_n)
    (skid_valid_r && !out_stall) |=> (!skid_valid_r && out_valid_r))
    else $error("skid beat not moved on after result taken");

  a_no_fire_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r |-> !fire)
    else $error("beat accepted with skid stage occupied");

endmodule

[sv/dual_rate_sample_capture_core.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dual_rate_sample_capture_core - dual rate sample capture, top level
//
//   channel  | handshake            | beat contents
//   ---------+----------------------+------------------------------------------
//   in_      | in_valid / in_stall  | three 16-bit channel samples of one tick
//   out_     | out_valid / out_stall| buffer write command for that tick
//   cfg_     | cfg_we               | cfg_index selects register, cfg_data value
//
// One tick is accepted per clock while in_stall is low; its command is
// registered in the result register. Index update is a combinational
// compare and increment in the index unit. Reset (rst_n low, synchronous)
// clears indices and phase and loads register defaults. A stalled sink is
// absorbed by a one-beat skid stage; in_stall rises only once it is occupied.
// ----------------------------------------------------------------------------
module dual_rate_sample_capture_core #(
  parameter int BUFFER_DEPTH = drsc_pkg::BUFFER_DEPTH_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_we,
  input  logic [drsc_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [drsc_pkg::CFG_DATA_W-1:0]   cfg_data,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic [drsc_pkg::SAMPLE_W-1:0]     in_ch1_sample,
  input  logic [drsc_pkg::SAMPLE_W-1:0]     in_ch2_sample,
  input  logic [drsc_pkg::SAMPLE_W-1:0]     in_ch3_sample,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [drsc_pkg::IDX_W-1:0]        out_ch1_addr,
  output logic [drsc_pkg::SAMPLE_W-1:0]     out_ch1_data,
  output logic [drsc_pkg::IDX_W-1:0]        out_slow_addr,
  output logic [drsc_pkg::SAMPLE_W-1:0]     out_ch2_data,
  output logic [drsc_pkg::SAMPLE_W-1:0]     out_ch3_data,
  output logic                              out_ch1_full,
  output logic                              out_block_done
);

  logic           fire;
  drsc_pkg::res_t res;
  drsc_pkg::res_t out_res;

  assign fire = in_valid && !in_stall;

  drsc_idx #(
    .BUFFER_DEPTH(BUFFER_DEPTH)
  ) u_idx (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .fire       (fire),
    .ch1_sample (in_ch1_sample),
    .ch2_sample (in_ch2_sample),
    .ch3_sample (in_ch3_sample),
    .res        (res)
  );

  drsc_skid u_skid (
    .clk       (clk),
    .rst_n     (rst_n),
    .fire      (fire),
    .res       (res),
    .up_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_res   (out_res)
  );

  assign out_ch1_addr   = out_res.ch1_addr;
  assign out_ch1_data   = out_res.ch1_data;
  assign out_slow_addr  = out_res.slow_addr;
  assign out_ch2_data   = out_res.ch2_data;
  assign out_ch3_data   = out_res.ch3_data;
  assign out_ch1_full   = out_res.ch1_full;
  assign out_block_done = out_res.block_done;

endmodule

[tb/drsc_write_cmd_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// drsc_write_cmd_checker - buffer write command scoreboard
// Tracks register writes and accepted sample beats, predicts the write
// command of each tick and compares every accepted command beat with it.
// ----------------------------------------------------------------------------
module drsc_write_cmd_checker #(
  parameter int BUFFER_DEPTH = drsc_pkg::BUFFER_DEPTH_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_we,
  input  logic [drsc_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [drsc_pkg::CFG_DATA_W-1:0]   cfg_data,
  input  logic                              in_valid,
  input  logic                              in_stall,
  input  logic [drsc_pkg::SAMPLE_W-1:0]     in_ch1_sample,
  input  logic [drsc_pkg::SAMPLE_W-1:0]     in_ch2_sample,
  input  logic [drsc_pkg::SAMPLE_W-1:0]     in_ch3_sample,
  input  logic                              out_valid,
  input  logic                              out_stall,
  input  logic [drsc_pkg::IDX_W-1:0]        out_ch1_addr,
  input  logic [drsc_pkg::SAMPLE_W-1:0]     out_ch1_data,
  input  logic [drsc_pkg::IDX_W-1:0]        out_slow_addr,
  input  logic [drsc_pkg::SAMPLE_W-1:0]     out_ch2_data,
  input  logic [drsc_pkg::SAMPLE_W-1:0]     out_ch3_data,
  input  logic                              out_ch1_full,
  input  logic                              out_block_done,
  output int                                fail_count,
  output int                                pending
);

  // top index either index may reach
  localparam int IDX_CAP = (BUFFER_DEPTH - 1 > 2047) ? 2047 : BUFFER_DEPTH - 1;

  logic [drsc_pkg::IDX_W-1:0]   ch1_len;
  logic [drsc_pkg::IDX_W-1:0]   ch23_len;
  logic [drsc_pkg::PHASE_W-1:0] ratio_reg;

  logic [drsc_pkg::IDX_W-1:0]   fast_idx;
  logic [drsc_pkg::IDX_W-1:0]   slow_idx;
  logic [drsc_pkg::PHASE_W-1:0] phase_cnt;

  drsc_pkg::res_t expected_cmds[$];
  int             err_cnt = 0;

  function automatic drsc_pkg::res_t predict_write_cmd(
    input logic [drsc_pkg::SAMPLE_W-1:0] s1,
    input logic [drsc_pkg::SAMPLE_W-1:0] s2,
    input logic [drsc_pkg::SAMPLE_W-1:0] s3
  );
    drsc_pkg::res_t               cmd;
    logic [drsc_pkg::PHASE_W-1:0] eff_ratio;
    logic [drsc_pkg::PHASE_W:0]   next_phase;
    cmd.ch1_addr  = fast_idx;
    cmd.ch1_data  = s1;
    cmd.slow_addr = slow_idx;
    cmd.ch2_data  = s2;
    cmd.ch3_data  = s3;
    eff_ratio = (ratio_reg == '0) ? 8'd1 : ratio_reg;
    if (fast_idx <= ch1_len && fast_idx < IDX_CAP) begin
      fast_idx = fast_idx + 1'b1;
    end
    // a ratio lowered below the running phase steps at once
    next_phase = {1'b0, phase_cnt} + 9'd1;
    if (next_phase >= {1'b0, eff_ratio}) begin
      phase_cnt = '0;
      if (slow_idx < IDX_CAP) begin
        slow_idx = slow_idx + 1'b1;
      end
    end else begin
      phase_cnt = next_phase[drsc_pkg::PHASE_W-1:0];
    end
    cmd.ch1_full   = fast_idx > ch1_len;
    cmd.block_done = slow_idx > ch23_len;
    if (cmd.block_done) begin
      fast_idx  = '0;
      slow_idx  = '0;
      phase_cnt = '0;
    end
    return cmd;
  endfunction

  task automatic check_field(input string name, input int unsigned exp_v,
                             input int unsigned act_v);
    if (exp_v != act_v) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, exp_v, act_v);
      err_cnt++;
    end
  endtask

  always @(posedge clk) begin
    drsc_pkg::res_t want;
    if (!rst_n) begin
      ch1_len   = drsc_pkg::CH1_LENGTH_RST;
      ch23_len  = drsc_pkg::CH23_LENGTH_RST;
      ratio_reg = drsc_pkg::DECIM_RATIO_RST;
      fast_idx  = '0;
      slow_idx  = '0;
      phase_cnt = '0;
      expected_cmds.delete();
    end else begin
      // a beat taken on the same edge as a register write sees the old value
      if (in_valid && !in_stall) begin
        expected_cmds.push_back(predict_write_cmd(in_ch1_sample, in_ch2_sample,
                                                  in_ch3_sample));
      end
      if (cfg_we) begin
        case (cfg_index)
          drsc_pkg::CFG_CH1_LENGTH:  ch1_len   = cfg_data[drsc_pkg::IDX_W-1:0];
          drsc_pkg::CFG_CH23_LENGTH: ch23_len  = cfg_data[drsc_pkg::IDX_W-1:0];
          drsc_pkg::CFG_DECIM_RATIO: ratio_reg = cfg_data[drsc_pkg::PHASE_W-1:0];
          default: ;
        endcase
      end
      if (out_valid && !out_stall) begin
        if (expected_cmds.size() == 0) begin
          $display("%0t: command beat with nothing expected, ch1_addr %0h slow_addr %0h",
                   $time, out_ch1_addr, out_slow_addr);
          err_cnt++;
        end else begin
          want = expected_cmds.pop_front();
          check_field("ch1_addr",   32'(want.ch1_addr),   32'(out_ch1_addr));
          check_field("ch1_data",   32'(want.ch1_data),   32'(out_ch1_data));
          check_field("slow_addr",  32'(want.slow_addr),  32'(out_slow_addr));
          check_field("ch2_data",   32'(want.ch2_data),   32'(out_ch2_data));
          check_field("ch3_data",   32'(want.ch3_data),   32'(out_ch3_data));
          check_field("ch1_full",   32'(want.ch1_full),   32'(out_ch1_full));
          check_field("block_done", 32'(want.block_done), 32'(out_block_done));
        end
      end
    end
    fail_count <= err_cnt;
    pending    <= expected_cmds.size();
  end

endmodule

[tb/tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb - dual rate sample capture core testbench
// Drives sample beats and register writes with random gaps and sink stalls;
// a scoreboard beside the core predicts and checks every write command.
// ----------------------------------------------------------------------------
module tb;

  localparam int                             DEPTH         = drsc_pkg::BUFFER_DEPTH_DEF;
  localparam logic [drsc_pkg::CFG_IDX_W-1:0] CFG_SPARE_IDX = 2'd3;
  localparam int                             RAND_TICKS    = 900;
  localparam int                             QUIET_FROM    = 760;

  logic                              clk;
  logic                              rst_n;
  logic                              cfg_we;
  logic [drsc_pkg::CFG_IDX_W-1:0]    cfg_index;
  logic [drsc_pkg::CFG_DATA_W-1:0]   cfg_data;
  logic                              in_valid;
  logic                              in_stall;
  logic [drsc_pkg::SAMPLE_W-1:0]     in_ch1_sample;
  logic [drsc_pkg::SAMPLE_W-1:0]     in_ch2_sample;
  logic [drsc_pkg::SAMPLE_W-1:0]     in_ch3_sample;
  logic                              out_valid;
  logic                              out_stall;
  logic [drsc_pkg::IDX_W-1:0]        out_ch1_addr;
  logic [drsc_pkg::SAMPLE_W-1:0]     out_ch1_data;
  logic [drsc_pkg::IDX_W-1:0]        out_slow_addr;
  logic [drsc_pkg::SAMPLE_W-1:0]     out_ch2_data;
  logic [drsc_pkg::SAMPLE_W-1:0]     out_ch3_data;
  logic                              out_ch1_full;
  logic                              out_block_done;

  int fail_count;
  int pending;
  bit gaps_on;
  int stall_left;
  int rand_ticks;

  dual_rate_sample_capture_core #(
    .BUFFER_DEPTH(DEPTH)
  ) uut (
    .clk(clk), .rst_n(rst_n),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_stall(in_stall),
    .in_ch1_sample(in_ch1_sample), .in_ch2_sample(in_ch2_sample),
    .in_ch3_sample(in_ch3_sample),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_ch1_addr(out_ch1_addr), .out_ch1_data(out_ch1_data),
    .out_slow_addr(out_slow_addr), .out_ch2_data(out_ch2_data),
    .out_ch3_data(out_ch3_data), .out_ch1_full(out_ch1_full),
    .out_block_done(out_block_done)
  );

  drsc_write_cmd_checker #(
    .BUFFER_DEPTH(DEPTH)
  ) scoreboard (
    .clk(clk), .rst_n(rst_n),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_stall(in_stall),
    .in_ch1_sample(in_ch1_sample), .in_ch2_sample(in_ch2_sample),
    .in_ch3_sample(in_ch3_sample),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_ch1_addr(out_ch1_addr), .out_ch1_data(out_ch1_data),
    .out_slow_addr(out_slow_addr), .out_ch2_data(out_ch2_data),
    .out_ch3_data(out_ch3_data), .out_ch1_full(out_ch1_full),
    .out_block_done(out_block_done),
    .fail_count(fail_count), .pending(pending)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #5_000_000;
    $display("[dual_rate_sample_capture_core] ERROR");
    $finish;
  end

  // sink side: stall in random bursts while gaps are enabled
  initial begin
    out_stall  = 1'b0;
    stall_left = 0;
    forever begin
      @(negedge clk);
      if (stall_left > 0) begin
        out_stall <= 1'b1;
        stall_left--;
      end else begin
        out_stall <= 1'b0;
        if (gaps_on && $urandom_range(0, 5) == 0) begin
          stall_left = $urandom_range(1, 12);
        end
      end
    end
  end

  // one sample beat; returns at the falling edge after acceptance
  task automatic send_tick(input logic [drsc_pkg::SAMPLE_W-1:0] s1,
                           input logic [drsc_pkg::SAMPLE_W-1:0] s2,
                           input logic [drsc_pkg::SAMPLE_W-1:0] s3);
    if (gaps_on && $urandom_range(0, 4) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(negedge clk);
    end
    in_valid      <= 1'b1;
    in_ch1_sample <= s1;
    in_ch2_sample <= s2;
    in_ch3_sample <= s3;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic send_random_ticks(input int count);
    repeat (count) begin
      send_tick(16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)),
                16'($urandom_range(0, 65535)));
    end
  endtask

  // drop valid and hold until every command beat has come back
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic write_reg(input logic [drsc_pkg::CFG_IDX_W-1:0] idx,
                           input logic [drsc_pkg::CFG_DATA_W-1:0] value);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(negedge clk);
    cfg_we    <= 1'b0;
    @(negedge clk);
  endtask

  task automatic pick_settings();
    logic [drsc_pkg::CFG_DATA_W-1:0] len1;
    logic [drsc_pkg::CFG_DATA_W-1:0] len23;
    logic [drsc_pkg::CFG_DATA_W-1:0] ratio_word;
    len1  = ($urandom_range(0, 9) == 0) ? 11'($urandom_range(0, 2047))
                                        : 11'($urandom_range(0, 48));
    len23 = ($urandom_range(0, 9) == 0) ? 11'($urandom_range(0, 2047))
                                        : 11'($urandom_range(0, 30));
    case ($urandom_range(0, 9))
      0:       ratio_word = 11'd255;
      1:       ratio_word = 11'($urandom_range(0, 2047));
      default: ratio_word = 11'($urandom_range(0, 6));
    endcase
    if ($urandom_range(0, 2) != 0) write_reg(drsc_pkg::CFG_CH1_LENGTH, len1);
    if ($urandom_range(0, 2) != 0) write_reg(drsc_pkg::CFG_CH23_LENGTH, len23);
    if ($urandom_range(0, 2) != 0) write_reg(drsc_pkg::CFG_DECIM_RATIO, ratio_word);
    if ($urandom_range(0, 7) == 0) write_reg(CFG_SPARE_IDX, 11'($urandom_range(0, 2047)));
  endtask

  initial begin
    int n;
    rst_n         = 1'b0;
    cfg_we        = 1'b0;
    cfg_index     = '0;
    cfg_data      = '0;
    in_valid      = 1'b0;
    in_ch1_sample = '0;
    in_ch2_sample = '0;
    in_ch3_sample = '0;
    gaps_on       = 1'b1;
    rand_ticks    = 0;
    repeat (10) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // reset settings, sample extremes and alternating bit patterns
    send_tick(16'h0000, 16'hFFFF, 16'hAAAA);
    send_tick(16'hFFFF, 16'h0000, 16'h5555);
    send_tick(16'hAAAA, 16'h5555, 16'h0000);
    send_tick(16'h5555, 16'hAAAA, 16'hFFFF);
    drain();

    // zero ch1 length and ratio, short block: full at once, block ends quickly
    write_reg(drsc_pkg::CFG_CH1_LENGTH, 11'd0);
    write_reg(drsc_pkg::CFG_CH23_LENGTH, 11'd2);
    write_reg(drsc_pkg::CFG_DECIM_RATIO, 11'd0);
    send_random_ticks(5);
    drain();

    // lower the ratio below a running phase
    write_reg(drsc_pkg::CFG_DECIM_RATIO, 11'd5);
    send_random_ticks(3);
    drain();
    write_reg(drsc_pkg::CFG_DECIM_RATIO, 11'd2);
    send_random_ticks(3);
    drain();

    // spare index ignored, ratio word masked to its top value
    write_reg(CFG_SPARE_IDX, 11'h7FF);
    write_reg(drsc_pkg::CFG_DECIM_RATIO, 11'h7FF);
    write_reg(drsc_pkg::CFG_CH23_LENGTH, 11'd0);
    send_random_ticks(3);
    drain();

    // lengths at the ceiling: both indices saturate, no flag rises
    write_reg(drsc_pkg::CFG_CH1_LENGTH, 11'd2047);
    write_reg(drsc_pkg::CFG_CH23_LENGTH, 11'd2047);
    write_reg(drsc_pkg::CFG_DECIM_RATIO, 11'd1);
    send_random_ticks(2060);
    drain();

    // channel one full just at the top index, block ends from a saturated index
    write_reg(drsc_pkg::CFG_CH1_LENGTH, 11'd2046);
    write_reg(drsc_pkg::CFG_CH23_LENGTH, 11'd5);
    send_random_ticks(4);
    drain();

    while (rand_ticks < RAND_TICKS) begin
      gaps_on = (rand_ticks < QUIET_FROM) && ($urandom_range(0, 3) != 0);
      pick_settings();
      n = $urandom_range(10, 70);
      send_random_ticks(n);
      rand_ticks += n;
      drain();
    end

    repeat (4) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("[dual_rate_sample_capture_core] OK");
    end else begin
      $display("[dual_rate_sample_capture_core] ERROR");
    end
    $finish;
  end

endmodule
